[src/spm_pkg.sv]
// Shared types and constants for the substring presence matcher.
`default_nettype none
package spm_pkg;

  localparam int unsigned PATTERN_MAX_DEFAULT = 128;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned OP_W = 2;
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned IN_TUSER_W = 2;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } spm_op_t;

  // Broadcast control from the top level to every cell of the row.
  typedef struct packed {
    logic              clr_match;
    logic              append;
    logic              text;
    logic [CHAR_W-1:0] chr;
  } spm_ctrl_t;

endpackage
`default_nettype wire

[src/spm_cell.sv]
// One pattern position: holds its pattern byte and its partial-match bit.
`default_nettype none
module spm_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned LEN_W    = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire spm_pkg::spm_ctrl_t ctrl,
  input  wire logic [LEN_W-1:0]  len,
  input  wire logic              prev_match,
  output logic                   match,
  output logic                   hit
);
  import spm_pkg::*;

  logic [CHAR_W-1:0] byte_r;
  logic              match_r;
  logic              match_nxt;
  logic              active;
  logic              wr_here;
  logic              is_last;
  logic              upd;

  // The cell takes part only while its position lies inside the pattern.
  assign active  = (len > LEN_W'(CELL_IDX));
  assign wr_here = ctrl.append && (len == LEN_W'(CELL_IDX));
  assign is_last = (len == LEN_W'(CELL_IDX + 1));
  assign upd     = prev_match && (byte_r == ctrl.chr);

  always_comb begin
    match_nxt = match_r;
    if (ctrl.clr_match) begin
      match_nxt = 1'b0;
    end else if (ctrl.text && active) begin
      match_nxt = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      byte_r <= ctrl.chr;
    end
  end

  assign match = match_r;
  assign hit   = ctrl.text && is_last && upd;

endmodule
`default_nettype wire

[src/substring_presence_matcher_unit.sv]
// Top level of the substring presence matcher: command decode, cell row and result register.
//
//  Channel | Direction | Handshake         | Payload
//  --------+-----------+-------------------+----------------------------------------------
//  in_     | input     | in_tvalid/tready  | in_tuser: opcode [1:0]; in_tdata: char_byte [7:0]
//  out_    | output    | out_tvalid/tready | out_tdata: found [0], pattern_clipped [1]
//
// The row of cells compares a text byte against all pattern positions at once, so one
// transaction is accepted in every cycle while the input is not stalled.
// An end-of-text command loads the result register; the input stalls only while that
// register holds a result the consumer has not taken.
// Reset empties the pattern, clears all partial-match bits and both flags; the pattern
// bytes themselves are not reset and are read only after they have been written.
`default_nettype none
module substring_presence_matcher_unit #(
  parameter int unsigned PATTERN_MAX = spm_pkg::PATTERN_MAX_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // char_byte [7:0]
  input  wire logic [spm_pkg::IN_TDATA_W-1:0] in_tdata,
  // opcode [1:0]
  input  wire logic [spm_pkg::IN_TUSER_W-1:0] in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // found [0], pattern_clipped [1], zero padding [7:2]
  output logic [spm_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import spm_pkg::*;

  localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);

  logic                 acc;
  spm_op_t              op;
  logic [CHAR_W-1:0]    chr;
  spm_ctrl_t            ctrl;

  logic [LEN_W-1:0]     len_r, len_nxt;
  logic                 clipped_r, clipped_nxt;
  logic                 found_r, found_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_clipped_r;

  logic [PATTERN_MAX-1:0] match_vec;
  logic [PATTERN_MAX-1:0] hit_vec;
  logic                   any_hit;

  assign acc = in_tvalid && in_tready;
  assign op  = spm_op_t'(in_tuser);
  assign chr = in_tdata;

  // The result register parts the two sides: input is taken whenever it is free
  // or being emptied in the same cycle.
  assign in_tready = !out_valid_r || out_tready;

  always_comb begin
    ctrl.clr_match = acc && ((op == OP_CLEAR) || (op == OP_END));
    ctrl.append    = acc && (op == OP_APPEND);
    ctrl.text      = acc && (op == OP_TEXT);
    ctrl.chr       = chr;
  end

  // Row of cells; each cell sees the match bit its left neighbor held last cycle,
  // which is the shift step of the partial-match vector.
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic prev;
    if (k == 0) begin : g_first
      assign prev = 1'b1;
    end else begin : g_rest
      assign prev = match_vec[k-1];
    end
    spm_cell #(
      .CELL_IDX(k),
      .LEN_W   (LEN_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .len       (len_r),
      .prev_match(prev),
      .match     (match_vec[k]),
      .hit       (hit_vec[k])
    );
  end

  // Only the cell at the last pattern position can raise a hit.
  assign any_hit = |hit_vec;

  always_comb begin
    len_nxt     = len_r;
    clipped_nxt = clipped_r;
    found_nxt   = found_r;
    if (acc) begin
      case (op)
        OP_CLEAR: begin
          len_nxt     = '0;
          clipped_nxt = 1'b0;
        end
        OP_APPEND: begin
          if (len_r < LEN_W'(PATTERN_MAX)) begin
            len_nxt = len_r + 1'b1;
          end else begin
            clipped_nxt = 1'b1;
          end
        end
        OP_TEXT: begin
          if (any_hit) begin
            found_nxt = 1'b1;
          end
        end
        OP_END: begin
          found_nxt = 1'b0;
        end
        default: begin
          len_nxt = len_r;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc && (op == OP_END)) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      clipped_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      clipped_r   <= clipped_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An empty pattern is found in every text, the empty text included.
  always_ff @(posedge clk) begin
    if (acc && (op == OP_END)) begin
      out_found_r   <= found_r || (len_r == '0);
      out_clipped_r <= clipped_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-2){1'b0}}, out_clipped_r, out_found_r};

  // The found flag is raised only by a text byte.
  a_found_from_text: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(found_r) |-> $past(acc && (op == OP_TEXT)))
    else $error("found flag raised without a text byte");

  // The pattern length never exceeds the number of cells.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(PATTERN_MAX))
    else $error("pattern length beyond capacity");

  // Clipping happens only on an append to a full pattern.
  a_clip_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(clipped_r) |-> $past(ctrl.append && (len_r == LEN_W'(PATTERN_MAX))))
    else $error("clipped flag raised while pattern not full");

  // End of text leaves a clean match state for the next text.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (op == OP_END)) |=> (!found_r && (match_vec == '0)))
    else $error("match state not cleared after end of text");

endmodule
`default_nettype wire

[sim/spm_verdict_checker.sv]
// Checker that predicts and compares the verdicts of the substring presence matcher.
`timescale 1ns / 100ps
module spm_verdict_checker #(
  parameter int unsigned PATTERN_MAX = spm_pkg::PATTERN_MAX_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  input  wire logic [spm_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [spm_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic [spm_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int unsigned                          mismatches,
  output int unsigned                          outstanding,
  output int unsigned                          verdicts_checked,
  output int unsigned                          found_hits
);
  import spm_pkg::*;

  typedef struct packed {
    logic found;
    logic clipped;
  } verdict_t;

  logic [CHAR_W-1:0] pattern_bytes [PATTERN_MAX];
  int unsigned       pattern_len;
  logic              match_bits [PATTERN_MAX];
  logic              found_sticky;
  logic              clipped_sticky;
  verdict_t          expected_verdicts [$];

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    mismatches = mismatches + 1;
    $display("[%0t] mismatch in %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Advances the predicted matcher state by one command and queues a verdict on end of text.
  task automatic absorb_command(spm_op_t op, logic [CHAR_W-1:0] chr);
    int n;
    n = int'(pattern_len);
    case (op)
      OP_CLEAR: begin
        pattern_len = 0;
        clipped_sticky = 1'b0;
        match_bits = '{default: 1'b0};
      end
      OP_APPEND: begin
        if (pattern_len < PATTERN_MAX) begin
          pattern_bytes[pattern_len] = chr;
          pattern_len = pattern_len + 1;
        end else begin
          clipped_sticky = 1'b1;
        end
      end
      OP_TEXT: begin
        if (n != 0) begin
          for (int k = n - 1; k > 0; k--) begin
            match_bits[k] = match_bits[k-1] && (pattern_bytes[k] == chr);
          end
          match_bits[0] = (pattern_bytes[0] == chr);
          if (match_bits[n-1]) begin
            found_sticky = 1'b1;
          end
        end
      end
      default: begin
        expected_verdicts.push_back('{found: (pattern_len == 0) || found_sticky,
                                      clipped: clipped_sticky});
        found_sticky = 1'b0;
        match_bits = '{default: 1'b0};
      end
    endcase
  endtask

  initial begin
    mismatches = 0;
    outstanding = 0;
    verdicts_checked = 0;
    found_hits = 0;
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      pattern_len = 0;
      match_bits = '{default: 1'b0};
      found_sticky = 1'b0;
      clipped_sticky = 1'b0;
      expected_verdicts.delete();
    end else begin
      // A verdict leaves only from the result register after its end-of-text command, so the output
      // side is settled before this cycle's command is absorbed.
      if (out_tvalid && out_tready) begin
        verdicts_checked = verdicts_checked + 1;
        if (out_tdata[0] === 1'b1) begin
          found_hits = found_hits + 1;
        end
        if (expected_verdicts.size() == 0) begin
          report_mismatch("verdict with nothing expected", out_tdata, 8'h00);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_tdata[0] !== want.found) begin
            report_mismatch("found", 8'(out_tdata[0]), 8'(want.found));
          end
          if (out_tdata[1] !== want.clipped) begin
            report_mismatch("pattern_clipped", 8'(out_tdata[1]), 8'(want.clipped));
          end
          if (out_tdata[OUT_TDATA_W-1:2] !== '0) begin
            report_mismatch("padding", 8'(out_tdata[OUT_TDATA_W-1:2]), 8'h00);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        absorb_command(spm_op_t'(in_tuser), in_tdata);
      end
    end
    outstanding = expected_verdicts.size();
  end

endmodule

[sim/tb_substring_presence_matcher_unit.sv]
// Testbench top for the substring presence matcher: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_substring_presence_matcher_unit;
  import spm_pkg::*;

  localparam int unsigned PATTERN_MAX = PATTERN_MAX_DEFAULT;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned verdicts_checked;
  int unsigned found_hits;

  // Per-opcode count of accepted transactions, for the closing summary.
  int unsigned op_count [4];
  int unsigned sent;
  // When set, neither side inserts idle cycles, giving back-to-back stretches.
  bit          steady;

  substring_presence_matcher_unit #(
    .PATTERN_MAX(PATTERN_MAX)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // The checker watches both channels on its own and hands back its counts.
  spm_verdict_checker #(
    .PATTERN_MAX(PATTERN_MAX)
  ) verdict_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .verdicts_checked(verdicts_checked),
    .found_hits      (found_hits)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  // Draws a byte either from a two-symbol alphabet, so that matches are frequent, or
  // from the whole byte range.
  function automatic logic [CHAR_W-1:0] pick_symbol(bit narrow, logic [CHAR_W-1:0] base,
                                                   logic [CHAR_W-1:0] flip);
    if (!narrow) begin
      return 8'($urandom);
    end
    return $urandom_range(0, 1) ? base : base ^ flip;
  endfunction

  // Offers one command and returns once the transaction has been accepted. Valid is
  // only lowered when a gap is actually inserted, so it never toggles within one step.
  task automatic send_cmd(spm_op_t op, logic [CHAR_W-1:0] chr);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= chr;
    do @(posedge clk); while (!in_tready);
    op_count[op] = op_count[op] + 1;
    sent = sent + 1;
  endtask

  // Holds the sender off until every predicted verdict has been delivered.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Run limit, far beyond the slowest legal run.
  initial begin
    #(5_000_000);
    $display("tb_substring_presence_matcher_unit failed");
    $finish;
  end

  // Result side: ready is high for random runs and dropped for random stalls.
  initial begin
    int unsigned run;
    int unsigned stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      run = $urandom_range(1, 16);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = steady ? 0 : pick_gap();
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    logic [CHAR_W-1:0] pat [$];
    logic [CHAR_W-1:0] txt [$];
    logic [CHAR_W-1:0] base;
    logic [CHAR_W-1:0] flip;
    int unsigned       plen;
    int unsigned       tlen;
    int unsigned       at;
    int unsigned       kind;
    bit                narrow;
    bit                broken;
    bit                long_done;
    bit                drained_mid;

    sent = 0;
    op_count = '{default: 0};
    steady = 1'b0;
    long_done = 1'b0;
    drained_mid = 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    rst_n     <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. An empty pattern is found at every end of text, even an empty one.
    send_cmd(OP_END, 8'hFF);
    send_cmd(OP_TEXT, 8'h00);
    send_cmd(OP_TEXT, 8'hFF);
    send_cmd(OP_END, 8'h00);
    // Pattern FF 00 built from the byte extremes, then found across a text of extremes.
    send_cmd(OP_APPEND, 8'hFF);
    send_cmd(OP_APPEND, 8'h00);
    send_cmd(OP_TEXT, 8'h00);
    send_cmd(OP_TEXT, 8'hFF);
    send_cmd(OP_TEXT, 8'h00);
    send_cmd(OP_END, 8'hA5);
    // The same pattern against a shorter text can never be found.
    send_cmd(OP_TEXT, 8'hFF);
    send_cmd(OP_END, 8'h5A);
    // Clearing the pattern mid-text keeps the found flag already raised in that text.
    send_cmd(OP_CLEAR, 8'hFF);
    send_cmd(OP_APPEND, 8'h41);
    send_cmd(OP_TEXT, 8'h41);
    send_cmd(OP_CLEAR, 8'h00);
    send_cmd(OP_APPEND, 8'h42);
    send_cmd(OP_END, 8'h3C);
    // Extending the pattern mid-text keeps the partial matches: pattern AB, A seen, C is
    // appended, and the text then completes ABC only if those bits survived.
    send_cmd(OP_CLEAR, 8'hC3);
    send_cmd(OP_APPEND, 8'h41);
    send_cmd(OP_APPEND, 8'h42);
    send_cmd(OP_TEXT, 8'h41);
    send_cmd(OP_APPEND, 8'h43);
    send_cmd(OP_TEXT, 8'h42);
    send_cmd(OP_TEXT, 8'h43);
    send_cmd(OP_END, 8'h7E);

    // The sender waits here until all directed verdicts have been taken.
    wait_for_drain();

    // Random part: mostly well-formed searches, some with stray commands mixed into the
    // text, plus bursts of arbitrary commands.
    while (sent < 550 || op_count[OP_END] < 45) begin
      steady = ($urandom_range(0, 7) == 0);
      if (!long_done && sent >= 200) begin
        // A pattern one byte past capacity is clipped; a text of exactly the stored
        // length of the same byte still finds it across the whole cell row.
        base = 8'($urandom);
        send_cmd(OP_CLEAR, base);
        repeat (PATTERN_MAX + 1) send_cmd(OP_APPEND, base);
        repeat (PATTERN_MAX) send_cmd(OP_TEXT, base);
        send_cmd(OP_END, ~base);
        send_cmd(OP_CLEAR, 8'($urandom));
        long_done = 1'b1;
      end else if (!drained_mid && sent >= 400) begin
        wait_for_drain();
        drained_mid = 1'b1;
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
          repeat ($urandom_range(1, 6)) send_cmd(spm_op_t'($urandom_range(0, 3)), 8'($urandom));
        end else begin
          broken = (kind < 30);
          narrow = ($urandom_range(0, 4) != 0);
          base = 8'($urandom);
          flip = 8'(1 << $urandom_range(0, 7));
          // Now and then the old pattern is kept and extended instead of cleared.
          if ($urandom_range(0, 4) != 0) begin
            send_cmd(OP_CLEAR, 8'($urandom));
          end
          plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
          pat.delete();
          repeat (plen) begin
            pat.push_back(pick_symbol(narrow, base, flip));
            send_cmd(OP_APPEND, pat[$]);
          end
          tlen = $urandom_range(0, 12);
          txt.delete();
          repeat (tlen) txt.push_back(pick_symbol(narrow, base, flip));
          // Plant the pattern somewhere in half of the texts that can hold it.
          if (plen != 0 && tlen >= plen && $urandom_range(0, 1) == 1) begin
            at = $urandom_range(0, tlen - plen);
            foreach (pat[i]) txt[at + i] = pat[i];
          end
          foreach (txt[i]) begin
            if (broken && $urandom_range(0, 6) == 0) begin
              send_cmd(spm_op_t'($urandom_range(0, 1)), pick_symbol(narrow, base, flip));
            end
            send_cmd(OP_TEXT, txt[i]);
          end
          // A broken sequence sometimes runs on into the next text without an end.
          if (!broken || $urandom_range(0, 3) != 0) begin
            send_cmd(OP_END, 8'($urandom));
          end
        end
      end
    end

    // Drain the last verdicts, then idle on for anything unexpected to show.
    steady = 1'b0;
    wait_for_drain();
    repeat (8) @(posedge clk);

    $display("Run covered %0d transactions: %0d clears, %0d appends, %0d text bytes, %0d ends.",
             sent, op_count[OP_CLEAR], op_count[OP_APPEND], op_count[OP_TEXT],
             op_count[OP_END]);
    $display("%0d verdicts checked, %0d of them with the pattern found.",
             verdicts_checked, found_hits);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_substring_presence_matcher_unit passed");
    end else begin
      $display("tb_substring_presence_matcher_unit failed");
    end
    $finish;
  end

endmodule
